// ----- src/ngll_pkg.sv -----
// Shared types, character codes and arithmetic constants of the GLL position parser.
`default_nettype none

package ngll_pkg;

  // Longest line kept, counted from the '$' on; the next byte discards it.
  localparam int LINE_MAX    = 80;
  // Fraction digits kept in each ddmm.mmmm number (1 to 5).
  localparam int FRAC_DIGITS = 5;

  localparam int COUNT_W = 7;
  localparam int INT_W   = 15;
  localparam int FRAC_W  = 17;

  // Integer part saturates at 18059; with the fraction all nines this is the cap.
  localparam logic [17:0] INT_LIMIT = 18'd18060;
  localparam logic [INT_W-1:0] INT_SAT = 15'd18059;

  // Exact floor(n/100) for n below 43690: (n * 5243) >> 19.
  localparam logic [12:0] RECIP100    = 13'd5243;
  localparam int          RECIP100_SH = 19;
  localparam logic [6:0]  MIN_DIV     = 7'd100;
  // Exact floor(y/15) for y below 2^28: (y * 286331154) >> 32.
  localparam logic [28:0] RECIP15     = 29'd286331154;
  localparam int          RECIP15_SH  = 32;
  localparam int          DEG_SCALE   = 10_000_000;

  localparam int CONV_STAGES = 5;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_L      = 8'h4C;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_W      = 8'h57;

  typedef enum logic [9:0] {
    PH_HDR     = 10'b00_0000_0001,
    PH_C1      = 10'b00_0000_0010,
    PH_LAT_PRE = 10'b00_0000_0100,
    PH_LAT_NUM = 10'b00_0000_1000,
    PH_LAT_HEM = 10'b00_0001_0000,
    PH_C3      = 10'b00_0010_0000,
    PH_LON_PRE = 10'b00_0100_0000,
    PH_LON_NUM = 10'b00_1000_0000,
    PH_LON_HEM = 10'b01_0000_0000,
    PH_DONE    = 10'b10_0000_0000
  } phase_t;

  // One coordinate as ddmm integer part, fraction in units of 10^-FRAC_DIGITS, sign.
  typedef struct packed {
    logic [INT_W-1:0]  int_part;
    logic [FRAC_W-1:0] frac;
    logic              neg;
  } coord_t;

  function automatic logic [23:0] pow10(input logic [2:0] e);
    logic [23:0] p;
    case (e)
      3'd0: p = 24'd1;
      3'd1: p = 24'd10;
      3'd2: p = 24'd100;
      3'd3: p = 24'd1000;
      3'd4: p = 24'd10000;
      3'd5: p = 24'd100000;
      3'd6: p = 24'd1000000;
      3'd7: p = 24'd10000000;
      default: p = 24'd1;
    endcase
    return p;
  endfunction

  // Expected header byte at a line position ('$' sits at position zero).
  function automatic logic [7:0] hdr_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd1: ch = CH_G;
      3'd2: ch = CH_P;
      3'd3: ch = CH_G;
      3'd4: ch = CH_L;
      3'd5: ch = CH_L;
      default: ch = CH_DOLLAR;
    endcase
    return ch;
  endfunction

  localparam logic [FRAC_W-1:0] SCALE    = FRAC_W'(pow10(3'(FRAC_DIGITS)));
  localparam logic [19:0]       FRAC_MUL = 20'(pow10(3'(7 - FRAC_DIGITS)));

endpackage

`default_nettype wire

// ----- src/ngll_parser.sv -----
// Per-byte line tracker and on-the-fly GLL field parser.
`default_nettype none

module ngll_parser import ngll_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  logic [7:0] rx_byte,
  output coord_t     lat,
  output coord_t     lon,
  output logic       line_emit
);

  localparam logic [COUNT_W-1:0] LINE_LIMIT = COUNT_W'(LINE_MAX);

  logic [COUNT_W-1:0] line_count, line_count_next;
  phase_t             phase, phase_next;
  logic               header_ok, header_ok_next;
  coord_t             lat_next, lon_next;
  logic [2:0]         frac_cnt, frac_cnt_next;
  logic               point_seen, point_seen_next;

  logic               is_digit, is_blank, is_hem, is_term, use_lat;
  logic [3:0]         digit;
  logic [17:0]        int_grow, frac_add;
  coord_t             num_in, num_out;
  logic               num_ok, num_point, clear_all;
  logic [2:0]         num_cnt;

  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign is_blank = (rx_byte == CH_SPACE) || (rx_byte == CH_TAB) ||
                    (rx_byte == CH_VT) || (rx_byte == CH_FF);
  assign is_hem   = (rx_byte == CH_S) || (rx_byte == CH_W);
  assign is_term  = (rx_byte == CH_LF) || (rx_byte == CH_CR);
  assign digit    = 4'(rx_byte - CH_ZERO);
  assign use_lat  = (phase == PH_LAT_PRE) || (phase == PH_LAT_NUM);
  assign num_in   = use_lat ? lat : lon;
  assign int_grow = 18'(num_in.int_part) * 18'd10 + 18'(digit);
  assign frac_add = 18'(num_in.frac) +
                    18'(digit) * 18'(pow10(3'(FRAC_DIGITS - 1) - frac_cnt));

  // One byte into the number: integer digits shift in, fraction digits land by place.
  always_comb begin
    num_out   = num_in;
    num_ok    = 1'b0;
    num_point = point_seen;
    num_cnt   = frac_cnt;
    if (is_digit) begin
      num_ok = 1'b1;
      if (!point_seen) begin
        if (int_grow >= INT_LIMIT) begin
          num_out.int_part = INT_SAT;
          num_out.frac     = SCALE - 1'b1;
        end else begin
          num_out.int_part = int_grow[INT_W-1:0];
        end
      end else if (frac_cnt < 3'(FRAC_DIGITS)) begin
        num_cnt = frac_cnt + 3'd1;
        if (frac_add >= 18'(SCALE)) begin
          num_out.int_part = INT_SAT;
          num_out.frac     = SCALE - 1'b1;
        end else begin
          num_out.frac = frac_add[FRAC_W-1:0];
        end
      end
    end else if ((rx_byte == CH_POINT) && !point_seen) begin
      num_ok    = 1'b1;
      num_point = 1'b1;
    end
  end

  always_comb begin
    line_count_next = line_count;
    phase_next      = phase;
    header_ok_next  = header_ok;
    lat_next        = lat;
    lon_next        = lon;
    frac_cnt_next   = frac_cnt;
    point_seen_next = point_seen;
    clear_all       = 1'b0;
    if (in_fire) begin
      if (line_count == '0) begin
        if (rx_byte == CH_DOLLAR) begin
          clear_all       = 1'b1;
          line_count_next = COUNT_W'(1);
        end
      end else if (line_count >= LINE_LIMIT || is_term) begin
        clear_all       = 1'b1;
        line_count_next = '0;
      end else begin
        line_count_next = line_count + 1'b1;
        if (rx_byte == CH_NUL) begin
          phase_next = PH_DONE;
        end else begin
          case (phase)
            PH_HDR: begin
              if (line_count < COUNT_W'(6) && rx_byte == hdr_char(line_count[2:0])) begin
                if (line_count == COUNT_W'(5)) begin
                  header_ok_next = 1'b1;
                  phase_next     = PH_C1;
                end
              end else begin
                phase_next = PH_DONE;
              end
            end
            PH_C1: phase_next = (rx_byte == CH_COMMA) ? PH_LAT_PRE : PH_DONE;
            PH_LAT_PRE, PH_LON_PRE: begin
              if (!is_blank) begin
                if (num_ok) begin
                  if (use_lat) lat_next = num_out;
                  else         lon_next = num_out;
                  point_seen_next = num_point;
                  frac_cnt_next   = num_cnt;
                  phase_next      = use_lat ? PH_LAT_NUM : PH_LON_NUM;
                end else begin
                  phase_next = PH_DONE;
                end
              end
            end
            PH_LAT_NUM, PH_LON_NUM: begin
              if (num_ok) begin
                if (use_lat) lat_next = num_out;
                else         lon_next = num_out;
                point_seen_next = num_point;
                frac_cnt_next   = num_cnt;
              end else if (rx_byte == CH_COMMA) begin
                phase_next      = use_lat ? PH_LAT_HEM : PH_LON_HEM;
                point_seen_next = 1'b0;
                frac_cnt_next   = '0;
              end else begin
                phase_next = PH_DONE;
              end
            end
            PH_LAT_HEM: begin
              lat_next.neg = is_hem;
              phase_next   = PH_C3;
            end
            PH_C3: phase_next = (rx_byte == CH_COMMA) ? PH_LON_PRE : PH_DONE;
            PH_LON_HEM: begin
              lon_next.neg = is_hem;
              phase_next   = PH_DONE;
            end
            default: phase_next = PH_DONE;
          endcase
        end
      end
    end
    if (clear_all) begin
      phase_next      = PH_HDR;
      header_ok_next  = 1'b0;
      lat_next        = '0;
      lon_next        = '0;
      frac_cnt_next   = '0;
      point_seen_next = 1'b0;
    end
  end

  // A zero value converts to zero degrees and only then; such a line gives no result.
  assign line_emit = in_fire && (line_count != '0) && (line_count < LINE_LIMIT) && is_term &&
                     header_ok && ({lat.int_part, lat.frac} != '0) &&
                     ({lon.int_part, lon.frac} != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count <= '0;
      phase      <= PH_HDR;
      header_ok  <= 1'b0;
      lat        <= '0;
      lon        <= '0;
      frac_cnt   <= '0;
      point_seen <= 1'b0;
    end else begin
      line_count <= line_count_next;
      phase      <= phase_next;
      header_ok  <= header_ok_next;
      lat        <= lat_next;
      lon        <= lon_next;
      frac_cnt   <= frac_cnt_next;
      point_seen <= point_seen_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/ngll_conv.sv -----
// Five-stage ddmm.mmmm to signed degrees*1e7 conversion datapath for one coordinate.
`default_nettype none

module ngll_conv import ngll_pkg::*; (
  input  logic                   clk,
  input  logic [CONV_STAGES-1:0] stage_en,
  input  coord_t                 coord,
  output logic signed [31:0]     value
);

  logic [27:0]       prod100;
  logic [56:0]       prod15;
  logic [31:0]       sum;

  logic [7:0]        q1, q2;
  logic [INT_W-1:0]  int1;
  logic [FRAC_W-1:0] frac1, frac2;
  logic [6:0]        r2;
  logic [29:0]       x3;
  logic [30:0]       dq3, dq4;
  logic [23:0]       m4;
  logic              neg1, neg2, neg3, neg4;

  assign prod100 = 28'(coord.int_part) * 28'(RECIP100);
  assign prod15  = 57'(x3 >> 2) * 57'(RECIP15);
  assign sum     = 32'(dq4) + 32'(m4);

  always_ff @(posedge clk) begin
    // Degrees: integer part divided by 100.
    if (stage_en[0]) begin
      q1    <= 8'(prod100 >> RECIP100_SH);
      int1  <= coord.int_part;
      frac1 <= coord.frac;
      neg1  <= coord.neg;
    end
    // Whole minutes left over.
    if (stage_en[1]) begin
      r2    <= 7'(int1 - 15'(q1) * 15'(MIN_DIV));
      q2    <= q1;
      frac2 <= frac1;
      neg2  <= neg1;
    end
    // Minutes times 1e7 and degrees times 1e7.
    if (stage_en[2]) begin
      x3   <= 30'(r2) * 30'(DEG_SCALE) + 30'(frac2) * 30'(FRAC_MUL);
      dq3  <= 31'(q2) * 31'(DEG_SCALE);
      neg3 <= neg2;
    end
    // Divide minutes by 60: shift right by 2 (divide by 4), then the reciprocal of 15.
    if (stage_en[3]) begin
      m4   <= 24'(prod15 >> RECIP15_SH);
      dq4  <= dq3;
      neg4 <= neg3;
    end
    if (stage_en[4]) begin
      value <= neg4 ? -sum : sum;
    end
  end

endmodule

`default_nettype wire

// ----- src/nmea_gll_position_parser.sv -----
// Top level of the NMEA GLL position parser: byte parser, conversion pipeline, handshakes.
`default_nettype none

// Feed one received character per in transaction; while in_ready is high the block
// takes a byte every clock cycle. A line opens at '$' and closes at CR or LF; a line
// that holds LINE_MAX bytes without a terminator is dropped together with the byte after
// it. The header must read "$GPGLL", followed by latitude ddmm.mmmm, hemisphere,
// longitude dddmm.mmmm, hemisphere. At the terminator a position is produced when the
// header matched and both values are nonzero: latitude and longitude in signed degrees
// times 1e7, negative for 'S' or 'W'. out_valid rises once the position has passed the
// five-stage conversion pipeline (divide by 100, split minutes, scale, divide by 60,
// sign), whose first stage loads on the edge that accepts the terminator. Each pipeline
// stage moves on its own when the stage after it is free, so in_ready stays high while
// a result waits at the output; it drops only when all five stages hold positions that
// the out side has not taken.
module nmea_gll_position_parser import ngll_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] latitude,
  output logic signed [31:0] longitude
);

  logic                   in_fire;
  logic                   job_valid;
  coord_t                 lat, lon;
  logic [CONV_STAGES-1:0] stage_valid;
  logic [CONV_STAGES-1:0] stage_en;

  assign in_fire = in_valid && in_ready;

  ngll_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .rx_byte   (rx_byte),
    .lat       (lat),
    .lon       (lon),
    .line_emit (job_valid)
  );

  // A stage may load when it is empty or its content moves on in the same cycle.
  always_comb begin
    stage_en[CONV_STAGES-1] = !stage_valid[CONV_STAGES-1] || out_ready;
    for (int k = CONV_STAGES - 2; k >= 0; k--) begin
      stage_en[k] = !stage_valid[k] || stage_en[k+1];
    end
  end

  assign in_ready  = stage_en[0];
  assign out_valid = stage_valid[CONV_STAGES-1];

  // Advance the valid flags alongside the data; stalled stages hold.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (stage_en[0]) stage_valid[0] <= job_valid;
      for (int k = 1; k < CONV_STAGES; k++) begin
        if (stage_en[k]) stage_valid[k] <= stage_valid[k-1];
      end
    end
  end

  ngll_conv u_conv_lat (
    .clk      (clk),
    .stage_en (stage_en),
    .coord    (lat),
    .value    (latitude)
  );

  ngll_conv u_conv_lon (
    .clk      (clk),
    .stage_en (stage_en),
    .coord    (lon),
    .value    (longitude)
  );

  // A position enters the pipeline only on an accepted line terminator.
  a_job_on_term: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> (in_fire && (rx_byte == CH_LF || rx_byte == CH_CR)))
    else $error("position issued without an accepted terminator");

  // Back pressure reaches the input only with the first stage occupied.
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (stage_valid[0] && !stage_en[1]))
    else $error("input stalled with a free first stage");

  // Emitted positions are never zero.
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (latitude != 32'sd0 && longitude != 32'sd0))
    else $error("zero coordinate delivered");

  // Converted magnitudes stay within the saturated range.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (latitude <= 32'sd1810000000 && latitude >= -32'sd1810000000 &&
                   longitude <= 32'sd1810000000 && longitude >= -32'sd1810000000))
    else $error("coordinate out of range");

endmodule

`default_nettype wire

// ----- tb/nmea_gll_checker.sv -----
// Checker for the GLL position parser: predicts position fixes and compares the out channel.
module nmea_gll_checker import ngll_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         rx_byte,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] latitude,
  input  logic signed [31:0] longitude,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] lat;
    logic signed [31:0] lon;
  } fix_t;

  localparam longint unsigned FRAC_UNIT = 10 ** FRAC_DIGITS;
  localparam longint unsigned FIX_CAP   = 18060 * FRAC_UNIT - 1;
  localparam longint unsigned DEG_E7    = 10_000_000;

  fix_t fix_q[$];

  // Sentence parser state, mirrored from the block's behavior.
  logic [6:0]  line_len;
  phase_t      phase;
  logic        hdr_match;
  logic [30:0] lat_val;
  logic [30:0] lon_val;
  logic        lat_neg;
  logic        lon_neg;
  logic [2:0]  frac_cnt;
  logic        point_on;
  string       gll_hdr = "$GPGLL";

  int fails;

  task automatic clear_fields();
    phase     = PH_HDR;
    hdr_match = 1'b0;
    lat_val   = '0;
    lat_neg   = 1'b0;
    lon_val   = '0;
    lon_neg   = 1'b0;
    frac_cnt  = '0;
    point_on  = 1'b0;
  endtask

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF;
  endfunction

  // Fold one character into a ddmm number scaled by 10^FRAC_DIGITS.
  task automatic take_num(input logic [7:0] c, inout logic [30:0] val, output bit used);
    longint unsigned v;
    longint unsigned d;
    longint unsigned w;
    v    = val;
    used = 1'b1;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
      if (!point_on) begin
        v = v * 10 + d * FRAC_UNIT;
      end else if (frac_cnt < FRAC_DIGITS) begin
        w = 1;
        for (int k = frac_cnt + 1; k < FRAC_DIGITS; k++) w = w * 10;
        v = v + d * w;
        frac_cnt = frac_cnt + 1'b1;
      end
      if (v > FIX_CAP) v = FIX_CAP;
      val = v[30:0];
    end else if (c == CH_POINT && !point_on) begin
      point_on = 1'b1;
    end else begin
      used = 1'b0;
    end
  endtask

  function automatic longint unsigned deg_e7_of(input logic [30:0] v);
    longint unsigned whole;
    longint unsigned mins;
    whole = v / (100 * FRAC_UNIT);
    mins  = v - whole * 100 * FRAC_UNIT;
    return whole * DEG_E7 + (mins * DEG_E7) / (60 * FRAC_UNIT);
  endfunction

  function automatic logic signed [31:0] apply_hemi(input longint unsigned mag, input logic neg);
    logic [31:0] m;
    m = mag[31:0];
    return neg ? -m : m;
  endfunction

  task automatic parse_char(input logic [7:0] c, input logic [6:0] pos);
    bit hem;
    bit used;
    hem = (c == CH_S || c == CH_W);
    if (c == CH_NUL) begin
      phase = PH_DONE;
    end else begin
      case (phase)
        PH_HDR: begin
          if (pos < 6 && c == gll_hdr[pos]) begin
            if (pos == 5) begin
              hdr_match = 1'b1;
              phase     = PH_C1;
            end
          end else begin
            phase = PH_DONE;
          end
        end
        PH_C1: phase = (c == CH_COMMA) ? PH_LAT_PRE : PH_DONE;
        PH_LAT_PRE: begin
          if (!is_blank(c)) begin
            take_num(c, lat_val, used);
            phase = used ? PH_LAT_NUM : PH_DONE;
          end
        end
        PH_LAT_NUM: begin
          take_num(c, lat_val, used);
          if (!used) begin
            if (c == CH_COMMA) begin
              phase    = PH_LAT_HEM;
              point_on = 1'b0;
              frac_cnt = '0;
            end else begin
              phase = PH_DONE;
            end
          end
        end
        PH_LAT_HEM: begin
          lat_neg = hem;
          phase   = PH_C3;
        end
        PH_C3: phase = (c == CH_COMMA) ? PH_LON_PRE : PH_DONE;
        PH_LON_PRE: begin
          if (!is_blank(c)) begin
            take_num(c, lon_val, used);
            phase = used ? PH_LON_NUM : PH_DONE;
          end
        end
        PH_LON_NUM: begin
          take_num(c, lon_val, used);
          if (!used) phase = (c == CH_COMMA) ? PH_LON_HEM : PH_DONE;
        end
        PH_LON_HEM: begin
          lon_neg = hem;
          phase   = PH_DONE;
        end
        default: phase = PH_DONE;
      endcase
    end
  endtask

  task automatic take_byte(input logic [7:0] c);
    longint unsigned la;
    longint unsigned lo;
    fix_t fix;
    if (line_len == 0) begin
      if (c == CH_DOLLAR) begin
        clear_fields();
        line_len = 7'd1;
      end
    end else if (line_len >= LINE_MAX) begin
      // overlong line: drop this byte and the whole line
      line_len = '0;
      clear_fields();
    end else if (c == CH_LF || c == CH_CR) begin
      la = deg_e7_of(lat_val);
      lo = deg_e7_of(lon_val);
      if (hdr_match && la != 0 && lo != 0) begin
        fix.lat = apply_hemi(la, lat_neg);
        fix.lon = apply_hemi(lo, lon_neg);
        fix_q.push_back(fix);
      end
      line_len = '0;
      clear_fields();
    end else begin
      parse_char(c, line_len);
      line_len = line_len + 1'b1;
    end
  endtask

  always @(posedge clk) begin
    fix_t want;
    if (rst) begin
      line_len = '0;
      clear_fields();
      fix_q.delete();
      fails   = 0;
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (fix_q.size() == 0) begin
          $display("%0t ns: unexpected fix, expected none, actual lat %0d lon %0d",
                   $time, latitude, longitude);
          fails++;
        end else begin
          want = fix_q.pop_front();
          if (latitude !== want.lat) begin
            $display("%0t ns: latitude mismatch, expected %0d, actual %0d",
                     $time, want.lat, latitude);
            fails++;
          end
          if (longitude !== want.lon) begin
            $display("%0t ns: longitude mismatch, expected %0d, actual %0d",
                     $time, want.lon, longitude);
            fails++;
          end
        end
      end
      if (in_valid && in_ready) take_byte(rx_byte);
      fail_count <= fails;
      pending    <= fix_q.size();
    end
  end

endmodule

// ----- tb/tb_nmea_gll_position_parser.sv -----
// Testbench top for the GLL position parser: byte stream stimulus, flow control and verdict.
module tb_nmea_gll_position_parser import ngll_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no transaction on either channel before the run is declared hung.
  // The slowest correct stretch is the long receiver hold-off plus a sender gap.
  localparam int WATCHDOG_LIMIT = 4000;
  // Long receiver hold-off; long enough to fill the five conversion stages.
  localparam int HOLD_CYCLES    = 300;
  // Settle time after the last fix; covers the five-stage conversion latency.
  localparam int DRAIN_CYCLES   = 20;
  // Clean sentences streamed against the long hold-off.
  localparam int CLEAN_LINES    = 12;
  // Random sentences in the closing phase.
  localparam int RANDOM_LINES   = 10;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         rx_byte;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] latitude;
  logic signed [31:0] longitude;

  int fail_count;
  int pending;

  // Bytes of the sentence being assembled, sent in order by send_line.
  logic [7:0] line_q[$];
  int         idle_cycles;
  bit         quiet;      // no sender gaps while set
  logic       hold_req;   // ask the receiver for its one long hold-off

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  nmea_gll_position_parser u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .latitude  (latitude),
    .longitude (longitude)
  );

  nmea_gll_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .latitude   (latitude),
    .longitude  (longitude),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Idle stretch length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one byte, optionally after a gap, and hold it until the block takes it.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = quiet ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i]);
    line_q.delete();
  endtask

  task automatic put_ch(input logic [7:0] b);
    line_q.push_back(b);
  endtask

  task automatic put(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic put_digit(input bit nonzero);
    put_ch(CH_ZERO + 8'(nonzero ? $urandom_range(1, 8) : $urandom_range(0, 9)));
  endtask

  // Directed helper: one sentence body closed by CR or LF.
  task automatic text_line(input string body, input bit use_lf);
    put(body);
    put_ch(use_lf ? CH_LF : CH_CR);
    send_line();
  endtask

  // Hold the sender idle until every predicted fix has come out.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // ddmm.mmmm number; clean ones are always nonzero and well formed.
  task automatic put_number(input bit is_lon, input bit clean);
    int r;
    int n_int;
    r = clean ? 99 : $urandom_range(0, 99);
    if (r < 5) return;                       // empty field
    if (r < 8) begin                         // lone point
      put(".");
      return;
    end
    if (r < 14) n_int = $urandom_range(6, 9);  // runs into saturation
    else n_int = is_lon ? $urandom_range(3, 5) : $urandom_range(2, 4);
    if (clean) n_int = is_lon ? 5 : 4;
    put_digit(clean);
    repeat (n_int - 1) put_digit(1'b0);
    if (clean || $urandom_range(0, 99) < 85) begin
      put(".");
      repeat (clean ? $urandom_range(2, 5) : $urandom_range(0, 7)) put_digit(1'b0);
    end
  endtask

  // Hemisphere byte: the field's positive letter, either negating letter in either field, any byte, or none at all.
  task automatic put_hemi(input bit is_lon, input bit clean);
    int r;
    r = $urandom_range(0, 99);
    if (clean) r = r % 80;
    if (r < 40) put_ch(is_lon ? "E" : "N");
    else if (r < 80) put_ch($urandom_range(0, 1) ? CH_W : CH_S);
    else if (r < 90) put_ch(8'($urandom_range(0, 255)));
  endtask

  task automatic put_blanks();
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(0, 3))
        0: put_ch(CH_SPACE);
        1: put_ch(CH_TAB);
        2: put_ch(CH_VT);
        default: put_ch(CH_FF);
      endcase
    end
  endtask

  task automatic put_end();
    case ($urandom_range(0, 2))
      0: begin
        put_ch(CH_CR);
        put_ch(CH_LF);
      end
      1: put_ch(CH_CR);
      default: put_ch(CH_LF);
    endcase
  endtask

  // Well-formed GLL sentence with random content; no noise, no damage.
  task automatic clean_sentence();
    put("$GPGLL,");
    put_number(1'b0, 1'b1);
    put(",");
    put_hemi(1'b0, 1'b1);
    put(",");
    put_number(1'b1, 1'b1);
    put(",");
    put_hemi(1'b1, 1'b1);
    put(",123519.00,A");
    put_end();
    send_line();
  endtask

  // Mostly well-formed sentence; some get line noise, a damaged byte or an overlong body.
  task automatic random_sentence();
    int s;
    int r;
    int target;
    quiet = ($urandom_range(0, 99) < 20);
    if ($urandom_range(0, 99) < 30) begin
      repeat ($urandom_range(1, 4)) put_ch(8'($urandom_range(0, 255)));
    end
    s = line_q.size();
    put("$GPGLL,");
    if ($urandom_range(0, 99) < 10) put_blanks();
    put_number(1'b0, 1'b0);
    put(",");
    put_hemi(1'b0, 1'b0);
    put(",");
    if ($urandom_range(0, 99) < 10) put_blanks();
    put_number(1'b1, 1'b0);
    put(",");
    put_hemi(1'b1, 1'b0);
    if ($urandom_range(0, 99) < 50) put(",225444.00,A");
    if ($urandom_range(0, 99) < 30) put("*4D");
    r = $urandom_range(0, 99);
    if (r < 8) begin
      line_q[s + $urandom_range(1, 5)] = 8'($urandom_range(0, 255));
    end else if (r < 16) begin
      line_q[s + $urandom_range(1, line_q.size() - s - 1)] = 8'($urandom_range(0, 255));
    end else if (r < 20) begin
      // stretch the line around the length limit
      target = $urandom_range(LINE_MAX - 4, LINE_MAX + 4);
      while (line_q.size() - s < target) put_ch(8'($urandom_range(33, 126)));
    end
    put_end();
    send_line();
  endtask

  // Receiver: random ready pattern, plus one long hold-off when asked.
  initial begin
    int on_len;
    int off;
    bit hold_taken;
    out_ready  = 1'b0;
    hold_taken = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        // Hold off while the sender keeps streaming, so the pipeline fills and in_ready drops.
        hold_taken = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        on_len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 6);
        repeat (1 + on_len) @(negedge clk);
        off = pick_gap();
        if (off > 0) begin
          out_ready <= 1'b0;
          repeat (off - 1) @(negedge clk);
        end
      end
    end
  end

  // Watchdog: end the run when no transaction happens for too long.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles", $time, idle_cycles);
      $display("[nmea_gll_position_parser] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int n_lines;
    rst        = 1'b1;
    in_valid   = 1'b0;
    rx_byte    = '0;
    quiet      = 1'b0;
    hold_req   = 1'b0;
    n_lines    = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // --- Directed sentences ---
    // Bytes outside any line, including all-ones and NUL, are dropped.
    put_ch(8'hFF);
    put_ch(CH_NUL);
    text_line("4916,N", 1'b1);
    // Plain fix, west negative; the LF after CR falls outside the line.
    put("$GPGLL,4916.45,N,12311.12,W,225444,A");
    put_ch(CH_CR);
    text_line("", 1'b1);
    text_line("$GPGLL,3751.65,S,14507.36,E", 1'b1);
    // Smallest nonzero values in both fields.
    text_line("$GPGLL,0000.00001,N,00000.00001,E", 1'b0);
    // Saturation at the top of the range, with extra digits.
    text_line("$GPGLL,99999.999999,S,123456789,W", 1'b0);
    // Leading blanks of every kind before each number.
    put("$GPGLL,");
    put_ch(CH_SPACE);
    put_ch(CH_TAB);
    put_ch(CH_VT);
    put_ch(CH_FF);
    put("1234.5,N,");
    put_ch(CH_TAB);
    text_line("01234.5,E", 1'b1);
    // Fraction digits beyond the kept precision get truncated.
    text_line("$GPGLL,1234.56789123,N,01234.9999999,E", 1'b0);
    // Lone point reads as zero: no fix. A trailing point alone is fine.
    text_line("$GPGLL,.,N,01000,E", 1'b0);
    text_line("$GPGLL,1000.,N,01000.,E", 1'b0);
    // Wrong header and a stray '$' inside the header: no fix.
    text_line("$GPGLA,4916.45,N,12311.12,W", 1'b0);
    text_line("$GP$GPGLL,4916.45,N,12311.12,W", 1'b1);
    // Malformed longitude freezes the parse; the digits so far are kept.
    text_line("$GPGLL,4916.45,N,123x1.12,W", 1'b0);
    // Second point breaks the latitude, longitude stays zero: no fix.
    text_line("$GPGLL,49.16.45,N,12311.12,W", 1'b0);
    // Hemisphere letters swapped between fields, then arbitrary bytes.
    text_line("$GPGLL,4916.45,W,12311.12,S", 1'b0);
    put("$GPGLL,4916.45,");
    put_ch(8'hFF);
    put(",12311.12,");
    put_ch(8'h80);
    put_ch(CH_CR);
    send_line();
    // Missing longitude hemisphere counts as positive.
    text_line("$GPGLL,4916.45,S,12311.12", 1'b0);
    // NUL inside the longitude freezes the parse.
    put("$GPGLL,4916.45,N,123");
    put_ch(CH_NUL);
    text_line("11.12,W", 1'b0);
    // Empty fields and a zero latitude: no fix.
    text_line("$GPGLL,,,,", 1'b0);
    text_line("$GPGLL,0000.0000,N,12311.12,W", 1'b0);
    // One byte short of the length limit still terminates normally.
    put("$GPGLL,4916.45,S,12311.12,E,");
    while (line_q.size() < LINE_MAX - 1) put("7");
    text_line("", 1'b0);
    // At the limit the terminator is dropped with the line; the LF is outside a line.
    put("$GPGLL,4916.45,S,12311.12,E,");
    while (line_q.size() < LINE_MAX) put("7");
    put_ch(CH_CR);
    text_line("", 1'b1);
    // At the limit a '$' is dropped too, so the following sentence is never opened.
    put("$GPGLL,4916.45,S,12311.12,E,");
    while (line_q.size() < LINE_MAX) put("7");
    text_line("$GPGLL,4916.45,N,12311.12,W", 1'b0);
    drain();

    // --- Back-pressure: stream clean sentences while the receiver holds off ---
    hold_req <= 1'b1;
    quiet = 1'b1;
    repeat (CLEAN_LINES) clean_sentence();
    quiet = 1'b0;
    drain();

    // --- Random sentences ---
    while (n_lines < RANDOM_LINES) begin
      random_sentence();
      n_lines++;
      // Pause now and then until the block has emptied.
      if (n_lines % 5 == 0) drain();
    end
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("[nmea_gll_position_parser] OK");
    end else begin
      $display("[nmea_gll_position_parser] ERROR");
    end
    $finish;
  end

endmodule
